// File: sv/column_to_span_converter_defines.svh
// Assertion helpers used by the column to span controller (c2s_ctrl).
`ifndef COLUMN_TO_SPAN_CONVERTER_DEFINES_SVH
`define COLUMN_TO_SPAN_CONVERTER_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define C2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checks that an antecedent is followed by its consequent in the next cycle.
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg) \
  `C2S_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/c2s_pkg.sv
`timescale 1ns / 1ps

package c2s_pkg;

  localparam int X_W       = 10;
  localparam int ROW_W     = 6;
  localparam int TOP_W     = 7;
  localparam int ROWS_DEF  = 64;
  localparam int MAX_CELLS = 2 ** ROW_W;

  // Only rows that a 6-bit row field can name ever need a cell.
  function automatic int cell_count(input int rows);
    return (rows < MAX_CELLS) ? rows : MAX_CELLS;
  endfunction

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_TOP,
    S_BOT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic             shift_up;
    logic             shift_dn;
    logic [X_W-1:0]   wr_x;
    logic             w1_en;
    logic [TOP_W-1:0] w1_lo;
    logic [TOP_W-1:0] w1_hi;
    logic             w2_en;
    logic [TOP_W-1:0] w2_lo;
    logic [TOP_W-1:0] w2_hi;
  } ring_ctrl_t;

endpackage

// File: sv/column_to_span_converter.sv
`timescale 1ns / 1ps
// After a column transfer the controller writes the opened rows (S_WRITE), then emits the top run
// and the bottom run; before each run the ring is turned the shorter way to the wanted row.
// No new column is accepted until the last span of the current one has been emitted.
// Spans of one run leave at one per cycle while the output is taken.
// Reset (rst, synchronous) clears every start column to zero and empties the output at once.

module column_to_span_converter #(
  parameter int ROWS = c2s_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           col_valid,
  output logic                           col_ready,
  input  logic [c2s_pkg::X_W-1:0]        column,
  input  logic [c2s_pkg::TOP_W-1:0]      prev_top,
  input  logic [c2s_pkg::ROW_W-1:0]      prev_bottom,
  input  logic [c2s_pkg::TOP_W-1:0]      cur_top,
  input  logic [c2s_pkg::ROW_W-1:0]      cur_bottom,
  output logic                           span_valid,
  input  logic                           span_ready,
  output logic [c2s_pkg::ROW_W-1:0]      span_row,
  output logic [c2s_pkg::X_W-1:0]        span_first_x,
  output logic signed [c2s_pkg::X_W-1:0] span_last_x,
  output logic                           last_span
);

  // Rows past the 6-bit row range can never be addressed, so the ring holds at most
  // one cell for each nameable row. Rows at or above ROWS read as zero.
  localparam int NCELL = c2s_pkg::cell_count(ROWS);
  localparam int TAG_W = $clog2(NCELL);

  // The start column store is a ring of cells. Each cell carries its row tag along with
  // the stored column, and the ring rotates one step per cycle in either direction.
  // Cell zero is the read point: the controller turns the ring until the wanted row sits
  // there, then emits it and keeps turning in the direction of the run, so consecutive
  // rows of a run come out one per cycle while the output is taken.
  logic [c2s_pkg::X_W-1:0] cell_data [NCELL];
  logic [TAG_W-1:0]        cell_tag  [NCELL];
  c2s_pkg::ring_ctrl_t     ring_ctl;

  // The controller decodes the closed and opened row ranges when a column transfer
  // completes. In the next cycle every cell in an opened range loads the column at once,
  // since those rows never overlap the rows that close. Then the closed rows are walked:
  // top rows ascending, bottom rows descending.
  c2s_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .col_valid    (col_valid),
    .col_ready    (col_ready),
    .column       (column),
    .prev_top     (prev_top),
    .prev_bottom  (prev_bottom),
    .cur_top      (cur_top),
    .cur_bottom   (cur_bottom),
    .span_valid   (span_valid),
    .span_ready   (span_ready),
    .span_row     (span_row),
    .span_first_x (span_first_x),
    .span_last_x  (span_last_x),
    .last_span    (last_span),
    .head_tag     (cell_tag[0]),
    .head_data    (cell_data[0]),
    .ring_ctl     (ring_ctl)
  );

  // Each cell takes from its upper neighbor when the ring turns up and from its lower
  // neighbor when it turns down; the ends wrap around.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int UP = (i + 1) % NCELL;
    localparam int DN = (i + NCELL - 1) % NCELL;

    c2s_cell #(
      .TAG_W (TAG_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ring_ctl),
      .above_data (cell_data[UP]),
      .above_tag  (cell_tag[UP]),
      .below_data (cell_data[DN]),
      .below_tag  (cell_tag[DN]),
      .data       (cell_data[i]),
      .tag        (cell_tag[i])
    );
  end

endmodule

// File: sv/c2s_cell.sv
`timescale 1ns / 1ps

// One entry of the rotating start-column ring. The row tag travels with the data.
module c2s_cell #(
  parameter int TAG_W = 6,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  c2s_pkg::ring_ctrl_t      ctl,
  input  logic [c2s_pkg::X_W-1:0]  above_data,
  input  logic [TAG_W-1:0]         above_tag,
  input  logic [c2s_pkg::X_W-1:0]  below_data,
  input  logic [TAG_W-1:0]         below_tag,
  output logic [c2s_pkg::X_W-1:0]  data,
  output logic [TAG_W-1:0]         tag
);

  logic [c2s_pkg::TOP_W-1:0] tag_ext;
  logic                      hit_w1;
  logic                      hit_w2;

  assign tag_ext = c2s_pkg::TOP_W'(tag);
  assign hit_w1  = ctl.w1_en && (tag_ext >= ctl.w1_lo) && (tag_ext <= ctl.w1_hi);
  assign hit_w2  = ctl.w2_en && (tag_ext >= ctl.w2_lo) && (tag_ext <= ctl.w2_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
      tag  <= TAG_W'(INDEX);
    end else if (ctl.wr_en && (hit_w1 || hit_w2)) begin
      data <= ctl.wr_x;
    end else if (ctl.shift_up) begin
      data <= above_data;
      tag  <= above_tag;
    end else if (ctl.shift_dn) begin
      data <= below_data;
      tag  <= below_tag;
    end
  end

endmodule

// File: sv/c2s_ctrl.sv
`timescale 1ns / 1ps
`include "column_to_span_converter_defines.svh"

// Range decode, ring steering and the span output register.
module c2s_ctrl #(
  parameter  int ROWS  = c2s_pkg::ROWS_DEF,
  localparam int NCELL = c2s_pkg::cell_count(ROWS),
  localparam int TAG_W = $clog2(NCELL)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          col_valid,
  output logic                          col_ready,
  input  logic [c2s_pkg::X_W-1:0]       column,
  input  logic [c2s_pkg::TOP_W-1:0]     prev_top,
  input  logic [c2s_pkg::ROW_W-1:0]     prev_bottom,
  input  logic [c2s_pkg::TOP_W-1:0]     cur_top,
  input  logic [c2s_pkg::ROW_W-1:0]     cur_bottom,
  output logic                          span_valid,
  input  logic                          span_ready,
  output logic [c2s_pkg::ROW_W-1:0]     span_row,
  output logic [c2s_pkg::X_W-1:0]       span_first_x,
  output logic signed [c2s_pkg::X_W-1:0] span_last_x,
  output logic                          last_span,
  input  logic [TAG_W-1:0]              head_tag,
  input  logic [c2s_pkg::X_W-1:0]       head_data,
  output c2s_pkg::ring_ctrl_t           ring_ctl
);

  localparam int TW = c2s_pkg::TOP_W;
  localparam int RW = c2s_pkg::ROW_W;
  localparam int XW = c2s_pkg::X_W;
  localparam int DW = TAG_W + 1;

  c2s_pkg::state_t state, state_next;

  logic [XW-1:0] x_reg;
  logic [XW-1:0] last_x;
  logic          top_en, bot_en;
  logic [RW-1:0] top_lo, top_hi, bot_lo, bot_hi;
  logic          w1_en, w2_en;
  logic [TW-1:0] w1_lo, w1_hi, w2_lo, w2_hi;
  logic [RW-1:0] cur;
  logic [XW-1:0] span_last_u;

  // Closed-form row ranges of one column.
  logic [TW-1:0] b1e, b2e, b1p, b2p, m1, t1f, lb, b1f, m2, t2f, b1fp, l2;
  logic          top_go, bot_go, w1_go, w2_go;

  logic          accept, slot_free, beyond, hit, emit, emit_last, phase_end, go_up;
  logic [DW-1:0] cur_e, head_e, ring_gap;

  assign accept = col_valid && col_ready;

  always_comb begin
    b1e    = TW'(prev_bottom);
    b2e    = TW'(cur_bottom);
    b1p    = b1e + TW'(1);
    b2p    = b2e + TW'(1);
    m1     = (cur_top < b1p) ? cur_top : b1p;
    top_go = prev_top < m1;
    t1f    = top_go ? m1 : prev_top;
    lb     = (b2p > t1f) ? b2p : t1f;
    bot_go = b1e >= lb;
    b1f    = bot_go ? (lb - TW'(1)) : b1e;
    m2     = (t1f < b2p) ? t1f : b2p;
    w1_go  = cur_top < m2;
    t2f    = w1_go ? m2 : cur_top;
    b1fp   = b1f + TW'(1);
    l2     = (b1fp > t2f) ? b1fp : t2f;
    w2_go  = b2e >= l2;
  end

  // Ring alignment: distance from the head row to the wanted row, going up.
  always_comb begin
    cur_e  = DW'(cur);
    head_e = DW'(head_tag);
    if (cur_e >= head_e) begin
      ring_gap = cur_e - head_e;
    end else begin
      ring_gap = cur_e + DW'(NCELL) - head_e;
    end
    go_up  = ring_gap <= DW'(NCELL / 2);
    beyond = TW'(cur) >= TW'(NCELL);
    hit    = head_e == cur_e;
  end

  // FSM outputs.
  always_comb begin
    col_ready         = 1'b0;
    emit              = 1'b0;
    emit_last         = 1'b0;
    phase_end         = 1'b0;
    slot_free         = !span_valid || span_ready;
    ring_ctl.wr_en    = 1'b0;
    ring_ctl.shift_up = 1'b0;
    ring_ctl.shift_dn = 1'b0;
    ring_ctl.wr_x     = x_reg;
    ring_ctl.w1_en    = w1_en;
    ring_ctl.w1_lo    = w1_lo;
    ring_ctl.w1_hi    = w1_hi;
    ring_ctl.w2_en    = w2_en;
    ring_ctl.w2_lo    = w2_lo;
    ring_ctl.w2_hi    = w2_hi;
    unique case (state)
      c2s_pkg::S_IDLE: begin
        col_ready = !rst;
      end
      c2s_pkg::S_WRITE: begin
        ring_ctl.wr_en = 1'b1;
      end
      c2s_pkg::S_TOP, c2s_pkg::S_BOT: begin
        emit = slot_free && (beyond || hit);
        if (state == c2s_pkg::S_TOP) begin
          phase_end = cur == top_hi;
          emit_last = phase_end && !bot_en;
        end else begin
          phase_end = cur == bot_lo;
          emit_last = phase_end;
        end
        if (!beyond) begin
          if (hit) begin
            ring_ctl.shift_up = emit && (state == c2s_pkg::S_TOP);
            ring_ctl.shift_dn = emit && (state == c2s_pkg::S_BOT);
          end else begin
            ring_ctl.shift_up = go_up;
            ring_ctl.shift_dn = !go_up;
          end
        end
      end
      default: begin
        col_ready = 1'b0;
      end
    endcase
  end

  // FSM next state.
  always_comb begin
    state_next = state;
    unique case (state)
      c2s_pkg::S_IDLE: begin
        if (accept) state_next = c2s_pkg::S_WRITE;
      end
      c2s_pkg::S_WRITE: begin
        if (top_en) begin
          state_next = c2s_pkg::S_TOP;
        end else if (bot_en) begin
          state_next = c2s_pkg::S_BOT;
        end else begin
          state_next = c2s_pkg::S_IDLE;
        end
      end
      c2s_pkg::S_TOP: begin
        if (emit && phase_end) begin
          state_next = bot_en ? c2s_pkg::S_BOT : c2s_pkg::S_IDLE;
        end
      end
      c2s_pkg::S_BOT: begin
        if (emit && phase_end) state_next = c2s_pkg::S_IDLE;
      end
      default: begin
        state_next = c2s_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= c2s_pkg::S_IDLE;
      span_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        span_valid <= 1'b1;
      end else if (span_ready) begin
        span_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg  <= column;
      last_x <= column - XW'(1);
      top_en <= top_go;
      top_lo <= prev_top[RW-1:0];
      top_hi <= RW'(m1 - TW'(1));
      bot_en <= bot_go;
      bot_lo <= lb[RW-1:0];
      bot_hi <= prev_bottom;
      w1_en  <= w1_go;
      w1_lo  <= cur_top;
      w1_hi  <= m2 - TW'(1);
      w2_en  <= w2_go;
      w2_lo  <= l2;
      w2_hi  <= b2e;
    end
    if (state == c2s_pkg::S_WRITE) begin
      cur <= top_en ? top_lo : bot_hi;
    end else if (emit) begin
      if (state == c2s_pkg::S_TOP) begin
        cur <= phase_end ? bot_hi : (cur + RW'(1));
      end else begin
        cur <= cur - RW'(1);
      end
    end
    if (emit) begin
      span_row     <= cur;
      span_first_x <= beyond ? '0 : head_data;
      span_last_u  <= last_x;
      last_span    <= emit_last;
    end
  end

  assign span_last_x = $signed(span_last_u);

  `C2S_ASSERT_NEXT(a_accept_writes, accept, state == c2s_pkg::S_WRITE, "accept did not start write")
  `C2S_ASSERT(a_top_cursor, (state == c2s_pkg::S_TOP) |-> (cur >= top_lo && cur <= top_hi), "top cursor out of range")
  `C2S_ASSERT(a_bot_cursor, (state == c2s_pkg::S_BOT) |-> (cur >= bot_lo && cur <= bot_hi), "bottom cursor out of range")
  `C2S_ASSERT_NEXT(a_last_idles, emit && emit_last, state == c2s_pkg::S_IDLE, "column did not end after last span")

endmodule
